FILE: hdl/deq_pkg.sv
package deq_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 11;

  // Default storage geometry.
  localparam int unsigned DEFAULT_DEPTH     = 1024;
  localparam int unsigned DEFAULT_WORD_BITS = 32;

  // Action codes carried by an input transaction.
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } act_e;

  // Controller sequencing states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_e;

endpackage

FILE: hdl/deq_if.sv
// Input channel: one deque action per transaction.
interface deq_in_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

// Output channel: one result per action.
interface deq_out_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped;
  logic                     underflow;
  logic                     overflow;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;

  modport source (
    output valid, popped, underflow, overflow, occupancy, is_empty, front_word, back_word,
    input ready
  );
  modport sink (
    input valid, popped, underflow, overflow, occupancy, is_empty, front_word, back_word,
    output ready
  );
endinterface

FILE: hdl/deq_mem.sv
module deq_mem import deq_pkg::*; #(
  parameter int unsigned DEPTH     = DEFAULT_DEPTH,
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS,
  localparam int unsigned AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned DEPTH     = DEFAULT_DEPTH,
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS,
  localparam int unsigned AW       = $clog2(DEPTH),
  localparam int unsigned CW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  deq_in_if.sink               cmd_i,
  deq_out_if.source            rsp_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic signed [WORD_W-1:0] front_q, front_d, back_q, back_d;
  logic signed [WORD_W-1:0] popped_q, popped_d;
  logic under_q, under_d, over_q, over_d;
  logic out_valid_q, out_valid_d;
  logic take_head_q, take_head_d;

  logic accept;
  logic full, empty;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
  logic signed [WORD_BITS-1:0] push_word;
  logic signed [WORD_W-1:0] push_ext, rd_ext;

  // Words are stored at WORD_BITS and sign-extended back to the port width.
  assign push_word = WORD_BITS'(cmd_i.value);
  assign push_ext  = WORD_W'(push_word);
  assign rd_ext    = WORD_W'(signed'(mem_rdata_i));

  // Circular pointer arithmetic, wrapping at DEPTH.
  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign tail_inc  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
  assign tail_dec  = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - AW'(1);
  assign tail_dec2 = (tail_dec == '0) ? AW'(DEPTH - 1) : tail_dec - AW'(1);

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // A new transaction is taken only when idle and the result slot frees up.
  assign cmd_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Next-state logic: pushes finish at acceptance, pops refill the end word.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    popped_d    = popped_q;
    under_d     = under_q;
    over_d      = over_q;
    take_head_d = take_head_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = push_word;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_inc;

    if (state_q == ST_FILL) begin
      // The read data now holds the new word at the end that was popped.
      if (take_head_q) begin
        front_d = rd_ext;
      end else begin
        back_d = rd_ext;
      end
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end else if (accept) begin
      popped_d    = '0;
      under_d     = 1'b0;
      over_d      = 1'b0;
      out_valid_d = 1'b1;
      case (cmd_i.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (full) begin
            over_d = 1'b1;
          end else if (cmd_i.action == ACT_PUSH_FRONT) begin
            head_d      = head_dec;
            mem_we_o    = 1'b1;
            mem_waddr_o = head_dec;
            front_d     = push_ext;
            if (empty) begin
              back_d = push_ext;
            end
            count_d = count_q + CW'(1);
          end else begin
            tail_d      = tail_inc;
            mem_we_o    = 1'b1;
            mem_waddr_o = tail_q;
            back_d      = push_ext;
            if (empty) begin
              front_d = push_ext;
            end
            count_d = count_q + CW'(1);
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (empty) begin
            under_d = 1'b1;
          end else begin
            count_d     = count_q - CW'(1);
            out_valid_d = 1'b0;
            state_d     = ST_FILL;
            mem_re_o    = 1'b1;
            if (cmd_i.action == ACT_POP_FRONT) begin
              popped_d    = front_q;
              head_d      = head_inc;
              mem_raddr_o = head_inc;
              take_head_d = 1'b1;
            end else begin
              popped_d    = back_q;
              tail_d      = tail_dec;
              mem_raddr_o = tail_dec2;
              take_head_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    popped_q    <= popped_d;
    under_q     <= under_d;
    over_q      <= over_d;
    take_head_q <= take_head_d;
  end

  // The state is frozen while a result waits, so the live state forms the result.
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.popped     = popped_q;
  assign rsp_o.underflow  = under_q;
  assign rsp_o.overflow   = over_q;
  assign rsp_o.occupancy  = OCC_W'(count_q);
  assign rsp_o.is_empty   = empty;
  assign rsp_o.front_word = empty ? '0 : front_q;
  assign rsp_o.back_word  = empty ? '0 : back_q;

  // The occupancy never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("deque count exceeds depth");

  // An empty deque has coinciding pointers.
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty |-> head_q == tail_q)
    else $error("pointers differ while empty");

  // No result is pending during the refill, and the controller is back in idle in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> !out_valid_q ##1 state_q == ST_IDLE)
    else $error("refill sequencing broken");

  // A successful pop raises the result valid once the refill state has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !empty && (cmd_i.action == ACT_POP_FRONT || cmd_i.action == ACT_POP_BACK)
    |=> ##1 out_valid_q)
    else $error("pop result missing");

  // A result never flags both underflow and overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> !(under_q && over_q))
    else $error("conflicting result flags");

endmodule

FILE: hdl/double_ended_queue_top.sv
// Double-ended queue of signed words held in a circular on-chip store.
// cmd_i carries one action per transaction: none, push front, push back,
// pop front or pop back, with the word to push. rsp_o returns exactly one
// result per action: the popped word, underflow and overflow flags, the
// occupancy, an empty flag, and the front and back words after the action.
// Both channels use a valid/ready handshake.
// A push, a rejected pop or push, or a no-op produces its result in the cycle
// after acceptance, and such actions can be taken every cycle while rsp_o.ready
// is high. A successful pop passes through a refill state: the store's single
// registered read port fetches the word that becomes the new front or back.
// The next action is accepted once that result has been registered.
// A result waits in the output register while rsp_o.ready is low; a new action
// is accepted in the same cycle the waiting result is taken.
// Reset empties the queue at once; the store contents are not cleared.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int unsigned DEPTH     = DEFAULT_DEPTH,
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    cmd_i,
  deq_out_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Pointer, count and end-word control.
  deq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Word store.
  deq_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
